FILE: rtl/core/utf8v_pkg.sv
// Package for the UTF-8 string validator.
// Holds the decoder state type and the code point limits; no dependencies.
`timescale 1ns / 1ps

package utf8v_pkg;

    typedef struct packed {
        logic [1:0]  pend;
        logic [1:0]  seq_len;
        logic [20:0] code_point;
        logic        error_seen;
    } utf8v_state_t;

    localparam logic [20:0] CP_MIN_2B      = 21'h00_0080;
    localparam logic [20:0] CP_MIN_3B      = 21'h00_0800;
    localparam logic [20:0] CP_MIN_4B      = 21'h01_0000;
    localparam logic [20:0] CP_MAX         = 21'h10_FFFF;
    localparam logic [20:0] CP_SURR_LO     = 21'h00_D800;
    localparam logic [20:0] CP_SURR_HI     = 21'h00_DFFF;
    localparam logic [20:0] CP_NONCHAR_LO  = 21'h00_FDD0;
    localparam logic [20:0] CP_NONCHAR_HI  = 21'h00_FDEF;
    localparam logic [15:0] CP_PLANE_END   = 16'hFFFE;

    localparam logic [1:0]  LEN_1B = 2'd0;
    localparam logic [1:0]  LEN_2B = 2'd1;
    localparam logic [1:0]  LEN_3B = 2'd2;
    localparam logic [1:0]  LEN_4B = 2'd3;

endpackage

FILE: rtl/core/utf8v_step.sv
// Single-byte UTF-8 decode step: next decoder state and string verdict.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_step (
    input  utf8v_pkg::utf8v_state_t state_cur,
    input  logic [7:0]              data_byte,
    input  logic                    byte_present,
    input  logic                    last_item,
    output utf8v_pkg::utf8v_state_t state_next,
    output logic                    string_valid
);

    function automatic logic point_ok(input logic [20:0] cp, input logic [1:0] len_m1);
        logic ok;
        logic nonchar;
        nonchar = ((cp[15:0] & utf8v_pkg::CP_PLANE_END) == utf8v_pkg::CP_PLANE_END) ||
                  (cp >= utf8v_pkg::CP_NONCHAR_LO && cp <= utf8v_pkg::CP_NONCHAR_HI);
        case (len_m1)
            utf8v_pkg::LEN_1B: ok = (cp != '0);
            utf8v_pkg::LEN_2B: ok = (cp >= utf8v_pkg::CP_MIN_2B);
            utf8v_pkg::LEN_3B: ok = (cp >= utf8v_pkg::CP_MIN_3B) &&
                                    !(cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI);
            default:           ok = (cp >= utf8v_pkg::CP_MIN_4B) && (cp <= utf8v_pkg::CP_MAX);
        endcase
        return ok && !nonchar;
    endfunction

    utf8v_pkg::utf8v_state_t st;
    logic [20:0]             cp_shift;
    logic [1:0]              pend_dec;

    assign cp_shift = {state_cur.code_point[14:0], data_byte[5:0]};
    assign pend_dec = state_cur.pend - 2'd1;

    always_comb begin
        st = state_cur;
        if (byte_present) begin
            if (state_cur.pend == 2'd0) begin
                if (data_byte[7] == 1'b0) begin
                    if (!point_ok({13'd0, data_byte}, utf8v_pkg::LEN_1B)) begin
                        st.error_seen = 1'b1;
                    end
                end else if (data_byte[7:5] == 3'b110) begin
                    st.seq_len    = utf8v_pkg::LEN_2B;
                    st.pend       = 2'd1;
                    st.code_point = {16'd0, data_byte[4:0]};
                end else if (data_byte[7:4] == 4'b1110) begin
                    st.seq_len    = utf8v_pkg::LEN_3B;
                    st.pend       = 2'd2;
                    st.code_point = {17'd0, data_byte[3:0]};
                end else if (data_byte[7:3] == 5'b11110) begin
                    st.seq_len    = utf8v_pkg::LEN_4B;
                    st.pend       = 2'd3;
                    st.code_point = {18'd0, data_byte[2:0]};
                end else begin
                    st.error_seen = 1'b1;
                end
            end else if (data_byte[7:6] != 2'b10) begin
                st.error_seen = 1'b1;
                st.pend       = 2'd0;
                st.seq_len    = 2'd0;
                st.code_point = '0;
            end else begin
                st.pend       = pend_dec;
                st.code_point = cp_shift;
                if (pend_dec == 2'd0) begin
                    if (!point_ok(cp_shift, state_cur.seq_len)) begin
                        st.error_seen = 1'b1;
                    end
                    st.seq_len    = 2'd0;
                    st.code_point = '0;
                end
            end
        end
    end

    assign string_valid = !st.error_seen && (st.pend == 2'd0);
    assign state_next   = last_item ? '0 : st;

endmodule

FILE: rtl/core/utf8_string_validator.sv
// UTF-8 string validator, top level: input register, decode step, result register.
// Last byte sits in the input register, then its verdict in the result register.
// Throughput: one byte per cycle, less when a last byte waits for m_ready.
// Reset: synchronous, active low; clears decoder state and both valid flags.
// Depends on utf8v_pkg and utf8v_step.
`timescale 1ns / 1ps

module utf8_string_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_byte_present,
    input  logic       s_last_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_string_valid
);

    logic                    s1_valid_reg;
    logic [7:0]              s1_byte_reg;
    logic                    s1_present_reg;
    logic                    s1_last_reg;
    utf8v_pkg::utf8v_state_t state_reg;
    utf8v_pkg::utf8v_state_t state_next;
    logic                    verdict_next;
    logic                    m_valid_reg;
    logic                    m_verdict_reg;
    logic                    out_free;
    logic                    s1_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_ready  = !s1_valid_reg || s1_fire;

    utf8v_step u_step (
        .state_cur    (state_reg),
        .data_byte    (s1_byte_reg),
        .byte_present (s1_present_reg),
        .last_item    (s1_last_reg),
        .state_next   (state_next),
        .string_valid (verdict_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_fire) begin
                state_reg <= state_next;
            end
            if (s1_fire && s1_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_byte_reg    <= s_data_byte;
            s1_present_reg <= s_byte_present;
            s1_last_reg    <= s_last_item;
        end
        if (s1_fire && s1_last_reg) begin
            m_verdict_reg <= verdict_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_string_valid = m_verdict_reg;

    a_pend_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pend <= state_reg.seq_len)
        else $error("pending continuations exceed sequence length");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.pend == 2'd0) |-> (state_reg.seq_len == 2'd0 && state_reg.code_point == '0))
        else $error("decoder state not clean between sequences");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_last_reg) |=> (state_reg == '0 && m_valid_reg))
        else $error("last byte did not clear state and post a verdict");

endmodule

FILE: verif/tb_utf8_string_validator.sv
// Testbench for utf8_string_validator: directed strings from a table, then random strings.
// Each verdict is typed in or predicted by a local UTF-8 decoder; depends on utf8v_pkg.
`timescale 1ns / 1ps

module tb_utf8_string_validator;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       fixed;
        logic       verdict;
    } stim_row_t;

    // data, byte present, last, verdict typed in, typed verdict
    localparam stim_row_t DIRECTED [0:27] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
        '{8'h7F, 1'b1, 1'b1, 1'b1, 1'b1},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{8'hC2, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'hC1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'hED, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'hA0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'hEF, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'hF4, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h8F, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'hBD, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'hF4, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h90, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'hE2, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h82, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
        '{8'hC3, 1'b1, 1'b0, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b1, 1'b0, 1'b0}
    };

    localparam int DIRECTED_ROWS = 28;

    localparam logic [20:0] EDGE_POINTS [0:17] = '{
        21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
        21'h00D800, 21'h00DFFF, 21'h00E000, 21'h00FDCF, 21'h00FDD0, 21'h00FDEF,
        21'h00FDF0, 21'h00FFFD, 21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF
    };

    localparam int RANDOM_ITEMS = 650;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_byte_present;
    logic       s_last_item;
    logic       m_valid;
    logic       m_ready;
    logic       m_string_valid;

    logic                    row_fixed;
    logic                    row_verdict;
    logic                    no_gaps;
    int                      items_done;
    int                      fail_count;
    logic                    pending_verdicts [$];
    stim_row_t               string_items [$];
    utf8v_pkg::utf8v_state_t decoder;

    utf8_string_validator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_string_valid (m_string_valid)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic point_legal(logic [20:0] cp, logic [1:0] len);
        logic ok;
        ok = 1'b1;
        case (len)
            utf8v_pkg::LEN_1B: if (cp == '0) ok = 1'b0;
            utf8v_pkg::LEN_2B: if (cp < utf8v_pkg::CP_MIN_2B) ok = 1'b0;
            utf8v_pkg::LEN_3B: begin
                if (cp < utf8v_pkg::CP_MIN_3B) ok = 1'b0;
                if (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI) ok = 1'b0;
            end
            default: if (cp < utf8v_pkg::CP_MIN_4B || cp > utf8v_pkg::CP_MAX) ok = 1'b0;
        endcase
        if ((cp[15:0] & utf8v_pkg::CP_PLANE_END) == utf8v_pkg::CP_PLANE_END) ok = 1'b0;
        if (cp >= utf8v_pkg::CP_NONCHAR_LO && cp <= utf8v_pkg::CP_NONCHAR_HI) ok = 1'b0;
        return ok;
    endfunction

    task automatic decode_byte(logic [7:0] b);
        if (decoder.pend == 2'd0) begin
            if (!b[7]) begin
                if (!point_legal({13'd0, b}, utf8v_pkg::LEN_1B)) decoder.error_seen = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                decoder.seq_len = utf8v_pkg::LEN_2B;
                decoder.pend = 2'd1;
                decoder.code_point = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                decoder.seq_len = utf8v_pkg::LEN_3B;
                decoder.pend = 2'd2;
                decoder.code_point = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                decoder.seq_len = utf8v_pkg::LEN_4B;
                decoder.pend = 2'd3;
                decoder.code_point = {18'd0, b[2:0]};
            end else begin
                decoder.error_seen = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            decoder.error_seen = 1'b1;
            decoder.pend = 2'd0;
            decoder.seq_len = utf8v_pkg::LEN_1B;
            decoder.code_point = '0;
        end else begin
            decoder.code_point = {decoder.code_point[14:0], b[5:0]};
            decoder.pend = decoder.pend - 2'd1;
            if (decoder.pend == 2'd0) begin
                if (!point_legal(decoder.code_point, decoder.seq_len))
                    decoder.error_seen = 1'b1;
                decoder.seq_len = utf8v_pkg::LEN_1B;
                decoder.code_point = '0;
            end
        end
    endtask

    // Decode each present byte, predict on each last transfer, check every verdict transfer.
    always @(posedge aclk) begin
        logic predicted;
        logic wanted;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_byte_present) decode_byte(s_data_byte);
                if (s_last_item) begin
                    predicted = !decoder.error_seen && decoder.pend == 2'd0;
                    pending_verdicts.push_back(row_fixed ? row_verdict : predicted);
                    decoder = '0;
                end
            end
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected verdict %b at %0t", m_string_valid, $realtime);
                end else begin
                    wanted = pending_verdicts.pop_front();
                    if (m_string_valid !== wanted) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("verdict mismatch at %0t: expected %b, got %b",
                                     $realtime, wanted, m_string_valid);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 13);
    end

    task automatic send_item(stim_row_t row);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= row.data;
        s_byte_present <= row.present;
        s_last_item <= row.last;
        row_fixed <= row.fixed;
        row_verdict <= row.verdict;
        do @(posedge aclk); while (!s_ready);
        if (row.present || row.last) items_done++;
    endtask

    task automatic drain_verdicts();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic add_byte(logic [7:0] d);
        stim_row_t row;
        row = '0;
        if ($urandom_range(0, 99) < 3) begin
            row.data = 8'($urandom_range(0, 255));
            string_items.push_back(row);
        end
        row.present = 1'b1;
        row.data = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(0, 255)) : d;
        string_items.push_back(row);
    endtask

    task automatic add_point();
        logic [20:0] cp;
        logic [1:0]  len;
        logic [4:0]  plane;
        int          pick;
        logic        cut;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            plane = 5'($urandom_range(0, 16));
            cp = {plane, 16'hFFFE} | 21'($urandom_range(0, 1));
        end else if (pick < 15) cp = EDGE_POINTS[$urandom_range(0, 17)];
        else if (pick < 45) cp = 21'($urandom_range(1, 127));
        else if (pick < 65) cp = 21'($urandom_range(128, 2047));
        else if (pick < 85) cp = 21'($urandom_range(2048, 65535));
        else cp = 21'($urandom_range(65536, 1114111));
        if (cp < utf8v_pkg::CP_MIN_2B) len = utf8v_pkg::LEN_1B;
        else if (cp < utf8v_pkg::CP_MIN_3B) len = utf8v_pkg::LEN_2B;
        else if (cp < utf8v_pkg::CP_MIN_4B) len = utf8v_pkg::LEN_3B;
        else len = utf8v_pkg::LEN_4B;
        if (len != utf8v_pkg::LEN_4B && $urandom_range(0, 99) < 6) len = len + 2'd1;
        cut = (len != utf8v_pkg::LEN_1B) && ($urandom_range(0, 99) < 4);
        case (len)
            utf8v_pkg::LEN_1B: add_byte(cp[7:0]);
            utf8v_pkg::LEN_2B: begin
                add_byte({3'b110, cp[10:6]});
                if (!cut) add_byte({2'b10, cp[5:0]});
            end
            utf8v_pkg::LEN_3B: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                if (!cut) add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                if (!cut) add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic send_string();
        stim_row_t tail;
        int        count;
        int        k;
        string_items.delete();
        count = $urandom_range(0, 5);
        if ($urandom_range(0, 99) < 10) begin
            for (k = 0; k <= count; k++) add_byte(8'($urandom_range(0, 255)));
        end else begin
            for (k = 0; k < count; k++) add_point();
        end
        if (string_items.size() == 0 || $urandom_range(0, 1) == 0) begin
            tail = '0;
            tail.data = 8'($urandom_range(0, 255));
            tail.last = 1'b1;
            string_items.push_back(tail);
        end else begin
            string_items[string_items.size() - 1].last = 1'b1;
        end
        foreach (string_items[j]) send_item(string_items[j]);
    endtask

    initial begin
        int  idx;
        logic paused;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = '0;
        s_byte_present = 1'b0;
        s_last_item = 1'b0;
        row_fixed = 1'b0;
        row_verdict = 1'b0;
        no_gaps = 1'b0;
        items_done = 0;
        fail_count = 0;
        paused = 1'b0;
        decoder = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        for (idx = 0; idx < DIRECTED_ROWS; idx++) send_item(DIRECTED[idx]);
        drain_verdicts();

        items_done = 0;
        while (items_done < RANDOM_ITEMS) begin
            no_gaps = (items_done >= 250 && items_done < 400);
            if (!paused && items_done >= 450) begin
                drain_verdicts();
                paused = 1'b1;
            end
            send_string();
        end
        no_gaps = 1'b0;
        drain_verdicts();
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
